// File: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define SIQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define SIQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/siq_pkg.sv
package siq_pkg;

    localparam int DEPTH     = 16;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int KEY_W     = 15;
    localparam int TAG_W     = 16;
    localparam int CNT_IN_W  = 16;
    localparam int PROD_W    = CNT_IN_W + KEY_W;
    localparam int PCT_SCALE = 100;
    localparam int FRAC_ONE  = 256;
    localparam int KEY_SCALE = PCT_SCALE * FRAC_ONE;
    localparam int DIV_STEPS = KEY_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    typedef logic [1:0] req_t;
    localparam req_t REQ_INSERT = 2'd0;
    localparam req_t REQ_POP    = 2'd1;
    localparam req_t REQ_DUMP   = 2'd2;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_FULL      = 2'd1;
    localparam status_t ST_EMPTY     = 2'd2;
    localparam status_t ST_BAD_RATIO = 2'd3;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_ROTATE,
        OP_INSERT
    } cell_op_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } entry_t;

    typedef struct packed {
        cell_op_t         op;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } cell_cmd_t;

endpackage

// File: rtl/siq_cell.sv
module siq_cell (
    input  logic               aclk,
    input  siq_pkg::cell_cmd_t cmd,
    input  logic               valid,
    input  logic               prev_stay,
    input  siq_pkg::entry_t    left_entry,
    input  siq_pkg::entry_t    right_entry,
    output siq_pkg::entry_t    entry,
    output logic               stay
);

    siq_pkg::entry_t entry_reg;
    siq_pkg::entry_t entry_next;

    // occupied and not below the new key: keeps its place on insert
    assign stay  = valid && (entry_reg.key >= cmd.key);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        case (cmd.op)
            siq_pkg::OP_ROTATE: begin
                entry_next = right_entry;
            end
            siq_pkg::OP_INSERT: begin
                if (!stay) begin
                    if (prev_stay) begin
                        entry_next.key = cmd.key;
                        entry_next.tag = cmd.tag;
                    end else begin
                        entry_next = left_entry;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

// File: rtl/siq_div.sv
module siq_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [siq_pkg::PROD_W-1:0]          dividend,
    input  logic [siq_pkg::CNT_IN_W-1:0]        divisor,
    output logic                                done,
    output logic [siq_pkg::KEY_W-1:0]           quotient
);

    logic                               busy_reg, busy_next;
    logic [siq_pkg::STEP_W-1:0]         step_reg, step_next;
    logic [siq_pkg::CNT_IN_W-1:0]       rem_reg, rem_next;
    logic [siq_pkg::KEY_W-1:0]          quo_reg, quo_next;
    logic [siq_pkg::CNT_IN_W-1:0]       dsr_reg, dsr_next;
    logic [siq_pkg::CNT_IN_W:0]         trial;
    logic [siq_pkg::CNT_IN_W:0]         diff;
    logic                               fits;
    logic                               last_step;

    assign trial     = {rem_reg, quo_reg[siq_pkg::KEY_W-1]};
    assign diff      = trial - {1'b0, dsr_reg};
    assign fits      = trial >= {1'b0, dsr_reg};
    assign last_step = step_reg == siq_pkg::STEP_W'(siq_pkg::DIV_STEPS - 1);
    assign done      = busy_reg && last_step;
    assign quotient  = quo_reg;

    // restoring division, one quotient bit per cycle; the quotient fits KEY_W
    // because the dividend is below divisor << KEY_W
    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = dividend[siq_pkg::PROD_W-1 -: siq_pkg::CNT_IN_W];
            quo_next  = dividend[siq_pkg::KEY_W-1:0];
            dsr_next  = divisor;
        end else if (busy_reg) begin
            rem_next  = fits ? diff[siq_pkg::CNT_IN_W-1:0] : trial[siq_pkg::CNT_IN_W-1:0];
            quo_next  = {quo_reg[siq_pkg::KEY_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (last_step) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

endmodule

// File: rtl/sorted_insert_queue_by_ratio_core.sv
// Sorted queue of up to 16 tagged entries, kept in descending order of
// key = floor(win_count * 25600 / match_count).
// Input channel s_*: one request per transaction (insert, pop, dump).
// Result channel m_*: status, tag, key and last for each result transaction.
// One request is handled at a time; s_ready is high only while idle, but a
// result waiting on m_* does not block acceptance of the next request.
// Insert: a 15-step serial divider computes the key, then the cell row
// places the entry in S_INS, and S_EMIT hands the result to m_*.
// Refused inserts (full list, bad ratio), pops and dumps of an empty list
// go from acceptance to S_EMIT; a pop rotates the head out.
// Dump: the row rotates left 16 times, one position per cycle except while
// an entry result cannot be handed over, showing the head on m_* for each
// stored entry; the next request is accepted once the last rotation is done.
// Request type 3 is dropped with no result.
// Reset (aresetn low, synchronous) empties the list and clears m_valid;
// no clearing pass is needed.
// A stalled receiver holds m_* steady; S_EMIT and the dump rotation wait for it.
module sorted_insert_queue_by_ratio_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_req_type,
    input  logic [siq_pkg::TAG_W-1:0]       s_player_tag,
    input  logic [siq_pkg::CNT_IN_W-1:0]    s_win_count,
    input  logic [siq_pkg::CNT_IN_W-1:0]    s_match_count,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_status,
    output logic [siq_pkg::TAG_W-1:0]       m_entry_tag,
    output logic [siq_pkg::KEY_W-1:0]       m_ratio_key,
    output logic                            m_last
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_INS  = 3'd2;
    localparam logic [2:0] S_EMIT = 3'd3;
    localparam logic [2:0] S_DUMP = 3'd4;

    logic [2:0]                         state_reg, state_next;
    logic [siq_pkg::CNT_W-1:0]          count_reg, count_next;
    logic [siq_pkg::IDX_W-1:0]          idx_reg, idx_next;
    siq_pkg::status_t                   res_status_reg, res_status_next;
    logic [siq_pkg::TAG_W-1:0]          res_tag_reg, res_tag_next;
    logic [siq_pkg::KEY_W-1:0]          res_key_reg, res_key_next;
    logic                               m_valid_reg, m_valid_next;
    siq_pkg::status_t                   m_status_reg, m_status_next;
    logic [siq_pkg::TAG_W-1:0]          m_tag_reg, m_tag_next;
    logic [siq_pkg::KEY_W-1:0]          m_key_reg, m_key_next;
    logic                               m_last_reg, m_last_next;

    siq_pkg::cell_cmd_t                 cmd;
    siq_pkg::entry_t                    entries [siq_pkg::DEPTH];
    logic                               stays   [siq_pkg::DEPTH];
    logic                               div_start;
    logic                               div_done;
    logic [siq_pkg::KEY_W-1:0]          div_quo;
    logic [siq_pkg::PROD_W-1:0]         dividend;
    logic                               accept;
    logic                               out_free;
    logic                               dump_emit;

    assign s_ready     = state_reg == S_IDLE;
    assign accept      = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign dump_emit   = siq_pkg::CNT_W'(idx_reg) < count_reg;
    assign dividend    = siq_pkg::PROD_W'(s_win_count) * siq_pkg::PROD_W'(siq_pkg::KEY_SCALE);

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_entry_tag = m_tag_reg;
    assign m_ratio_key = m_key_reg;
    assign m_last      = m_last_reg;

    siq_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (s_match_count),
        .done     (div_done),
        .quotient (div_quo)
    );

    for (genvar i = 0; i < siq_pkg::DEPTH; i++) begin : g_cell
        siq_cell u_cell (
            .aclk        (aclk),
            .cmd         (cmd),
            .valid       (siq_pkg::CNT_W'(i) < count_reg),
            .prev_stay   ((i == 0) ? 1'b1 : stays[(i + siq_pkg::DEPTH - 1) % siq_pkg::DEPTH]),
            .left_entry  (entries[(i + siq_pkg::DEPTH - 1) % siq_pkg::DEPTH]),
            .right_entry (entries[(i + 1) % siq_pkg::DEPTH]),
            .entry       (entries[i]),
            .stay        (stays[i])
        );
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_tag_next    = res_tag_reg;
        res_key_next    = res_key_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_tag_next      = m_tag_reg;
        m_key_next      = m_key_reg;
        m_last_next     = m_last_reg;
        cmd.op          = siq_pkg::OP_HOLD;
        cmd.key         = div_quo;
        cmd.tag         = res_tag_reg;
        div_start       = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    res_key_next = '0;
                    case (s_req_type)
                        siq_pkg::REQ_INSERT: begin
                            res_tag_next = s_player_tag;
                            if (count_reg == siq_pkg::CNT_W'(siq_pkg::DEPTH)) begin
                                res_status_next = siq_pkg::ST_FULL;
                                state_next      = S_EMIT;
                            end else if (s_match_count == '0 ||
                                         s_win_count > s_match_count) begin
                                res_status_next = siq_pkg::ST_BAD_RATIO;
                                state_next      = S_EMIT;
                            end else begin
                                div_start  = 1'b1;
                                state_next = S_DIV;
                            end
                        end
                        siq_pkg::REQ_POP: begin
                            state_next = S_EMIT;
                            if (count_reg == '0) begin
                                res_status_next = siq_pkg::ST_EMPTY;
                                res_tag_next    = '0;
                            end else begin
                                res_status_next = siq_pkg::ST_OK;
                                res_tag_next    = entries[0].tag;
                                res_key_next    = entries[0].key;
                                cmd.op          = siq_pkg::OP_ROTATE;
                                count_next      = count_reg - 1'b1;
                            end
                        end
                        siq_pkg::REQ_DUMP: begin
                            if (count_reg == '0) begin
                                res_status_next = siq_pkg::ST_EMPTY;
                                res_tag_next    = '0;
                                state_next      = S_EMIT;
                            end else begin
                                idx_next   = '0;
                                state_next = S_DUMP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (div_done) begin
                    state_next = S_INS;
                end
            end
            S_INS: begin
                cmd.op          = siq_pkg::OP_INSERT;
                res_status_next = siq_pkg::ST_OK;
                res_key_next    = div_quo;
                count_next      = count_reg + 1'b1;
                state_next      = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_tag_next    = res_tag_reg;
                    m_key_next    = res_key_reg;
                    m_last_next   = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_DUMP: begin
                // full rotation restores the original order
                if (out_free || !dump_emit) begin
                    cmd.op   = siq_pkg::OP_ROTATE;
                    idx_next = idx_reg + 1'b1;
                    if (dump_emit) begin
                        m_valid_next  = 1'b1;
                        m_status_next = siq_pkg::ST_OK;
                        m_tag_next    = entries[0].tag;
                        m_key_next    = entries[0].key;
                        m_last_next   = siq_pkg::CNT_W'(idx_reg) == count_reg - 1'b1;
                    end
                    if (idx_reg == siq_pkg::IDX_W'(siq_pkg::DEPTH - 1)) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_status_reg <= res_status_next;
        res_tag_reg    <= res_tag_next;
        res_key_reg    <= res_key_next;
        m_status_reg   <= m_status_next;
        m_tag_reg      <= m_tag_next;
        m_key_reg      <= m_key_next;
        m_last_reg     <= m_last_next;
    end

endmodule

// File: rtl/siq_checker.sv
`include "assert_macros.svh"

module siq_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [1:0]                      m_status,
    input logic [siq_pkg::TAG_W-1:0]       m_entry_tag,
    input logic [siq_pkg::KEY_W-1:0]       m_ratio_key,
    input logic                            m_last
);

    `SIQ_ASSERT_ALWAYS(a_reset_clears_valid, aclk, !aresetn |=> !m_valid, "m_valid after reset")

    `SIQ_ASSERT(a_stall_holds, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_entry_tag) && $stable(m_ratio_key) && $stable(m_last), "result changed while stalled")

    `SIQ_ASSERT(a_error_is_last, aclk, aresetn, m_valid && (m_status != siq_pkg::ST_OK) |-> m_last && (m_ratio_key == '0), "error result not final or key nonzero")

    `SIQ_ASSERT(a_key_range, aclk, aresetn, m_valid |-> m_ratio_key <= siq_pkg::KEY_W'(siq_pkg::KEY_SCALE), "key above full scale")

endmodule

bind sorted_insert_queue_by_ratio_core siq_checker u_siq_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_status    (m_status),
    .m_entry_tag (m_entry_tag),
    .m_ratio_key (m_ratio_key),
    .m_last      (m_last)
);

// File: verif/tb_sorted_insert_queue_by_ratio_core.sv
module tb_sorted_insert_queue_by_ratio_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam siq_pkg::req_t REQ_IGNORED   = 2'd3;
    localparam int            CYCLE_LIMIT   = 1000000;
    localparam int            DRAIN_CYCLES  = 40;
    localparam int            RANDOM_PHASES = 12;
    localparam int            PHASE_ITEMS   = 37;

    typedef struct packed {
        siq_pkg::status_t          status;
        logic [siq_pkg::TAG_W-1:0] tag;
        logic [siq_pkg::KEY_W-1:0] key;
        logic                      last;
    } ranked_result_t;

    class ratio_queue_scoreboard;
        logic [siq_pkg::KEY_W-1:0] key_row[siq_pkg::DEPTH];
        logic [siq_pkg::TAG_W-1:0] tag_row[siq_pkg::DEPTH];
        int                        fill;
        ranked_result_t            awaited[$];
        int                        mismatches;

        function new();
            fill       = 0;
            mismatches = 0;
        endfunction

        function void add_result(siq_pkg::status_t st, logic [siq_pkg::TAG_W-1:0] tag,
                                 logic [siq_pkg::KEY_W-1:0] key, logic last);
            ranked_result_t r;
            r.status = st;
            r.tag    = tag;
            r.key    = key;
            r.last   = last;
            awaited.push_back(r);
        endfunction

        function void note_request(siq_pkg::req_t req, logic [siq_pkg::TAG_W-1:0] tag,
                                   logic [15:0] win, logic [15:0] match);
            logic [31:0]               prod;
            logic [siq_pkg::KEY_W-1:0] key;
            int                        pos;
            case (req)
                siq_pkg::REQ_INSERT: begin
                    if (fill >= siq_pkg::DEPTH) begin
                        add_result(siq_pkg::ST_FULL, tag, '0, 1'b1);
                    end else if (match == 16'd0 || win > match) begin
                        add_result(siq_pkg::ST_BAD_RATIO, tag, '0, 1'b1);
                    end else begin
                        prod = 32'(win) * 32'(siq_pkg::KEY_SCALE);
                        key  = siq_pkg::KEY_W'(prod / 32'(match));
                        pos  = 0;
                        while (pos < fill && key_row[pos] >= key) pos++;
                        for (int i = fill; i > pos; i--) begin
                            key_row[i] = key_row[i-1];
                            tag_row[i] = tag_row[i-1];
                        end
                        key_row[pos] = key;
                        tag_row[pos] = tag;
                        fill++;
                        add_result(siq_pkg::ST_OK, tag, key, 1'b1);
                    end
                end
                siq_pkg::REQ_POP: begin
                    if (fill == 0) begin
                        add_result(siq_pkg::ST_EMPTY, '0, '0, 1'b1);
                    end else begin
                        add_result(siq_pkg::ST_OK, tag_row[0], key_row[0], 1'b1);
                        for (int i = 1; i < fill; i++) begin
                            key_row[i-1] = key_row[i];
                            tag_row[i-1] = tag_row[i];
                        end
                        fill--;
                    end
                end
                siq_pkg::REQ_DUMP: begin
                    if (fill == 0) begin
                        add_result(siq_pkg::ST_EMPTY, '0, '0, 1'b1);
                    end else begin
                        for (int i = 0; i < fill; i++) begin
                            add_result(siq_pkg::ST_OK, tag_row[i], key_row[i], (i == fill - 1));
                        end
                    end
                end
                default: begin
                end
            endcase
        endfunction

        function void check_result(logic [1:0] st, logic [siq_pkg::TAG_W-1:0] tag,
                                   logic [siq_pkg::KEY_W-1:0] key, logic last);
            ranked_result_t e;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status=%0d tag=%h key=%0d last=%0b",
                             st, tag, key, last);
                return;
            end
            e = awaited.pop_front();
            if (st !== e.status || tag !== e.tag || key !== e.key || last !== e.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp status=%0d tag=%h key=%0d last=%0b, %s%0d %s%h %s%0d %s%0b",
                             e.status, e.tag, e.key, e.last,
                             "got status=", st, "tag=", tag, "key=", key, "last=", last);
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                         aclk;
    logic                         aresetn;
    logic                         s_valid;
    logic                         s_ready;
    logic [1:0]                   s_req_type;
    logic [siq_pkg::TAG_W-1:0]    s_player_tag;
    logic [siq_pkg::CNT_IN_W-1:0] s_win_count;
    logic [siq_pkg::CNT_IN_W-1:0] s_match_count;
    logic                         m_valid;
    logic                         m_ready;
    logic [1:0]                   m_status;
    logic [siq_pkg::TAG_W-1:0]    m_entry_tag;
    logic [siq_pkg::KEY_W-1:0]    m_ratio_key;
    logic                         m_last;

    ratio_queue_scoreboard sb = new();
    int                    cycles = 0;
    int                    burst_left = 0;

    sorted_insert_queue_by_ratio_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_player_tag  (s_player_tag),
        .s_win_count   (s_win_count),
        .s_match_count (s_match_count),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_entry_tag   (m_entry_tag),
        .m_ratio_key   (m_ratio_key),
        .m_last        (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_status, m_entry_tag, m_ratio_key, m_last);
    end

    // receiver stall pattern, independent of the sender
    initial begin
        int  mode;
        int  len;
        int  hold;
        logic lvl;
        m_ready <= 1'b0;
        lvl  = 1'b0;
        hold = 0;
        forever begin
            mode = $urandom_range(3, 0);
            len  = $urandom_range(120, 20);
            repeat (len) begin
                @(posedge aclk);
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(1, 0));
                    2: m_ready <= ($urandom_range(9, 0) != 0);
                    default: begin
                        if (hold == 0) begin
                            lvl  = !lvl;
                            hold = lvl ? $urandom_range(8, 1) : $urandom_range(20, 1);
                        end
                        hold--;
                        m_ready <= lvl;
                    end
                endcase
            end
        end
    end

    task automatic send_req(siq_pkg::req_t req, logic [siq_pkg::TAG_W-1:0] tag,
                            logic [15:0] win, logic [15:0] match);
        s_valid       <= 1'b1;
        s_req_type    <= req;
        s_player_tag  <= tag;
        s_win_count   <= win;
        s_match_count <= match;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(req, tag, win, match);
    endtask

    task automatic idle_cycles(int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic pace();
        if (burst_left == 0) begin
            idle_cycles($urandom_range(8, 1));
            burst_left = ($urandom_range(7, 0) == 0) ? $urandom_range(60, 20)
                                                      : $urandom_range(16, 1);
        end else begin
            burst_left--;
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    initial begin
        int            ins_pct;
        int            roll;
        int            sent;
        int            variant;
        siq_pkg::req_t req;
        logic [15:0]   tag;
        logic [15:0]   win;
        logic [15:0]   match;

        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_req_type    <= siq_pkg::REQ_INSERT;
        s_player_tag  <= '0;
        s_win_count   <= '0;
        s_match_count <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part
        send_req(siq_pkg::REQ_POP, 16'h1234, 16'd5, 16'd9);
        send_req(siq_pkg::REQ_DUMP, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_req(REQ_IGNORED, 16'hABCD, 16'd1, 16'd2);
        send_req(siq_pkg::REQ_INSERT, 16'hFFFF, 16'd0, 16'd0);
        send_req(siq_pkg::REQ_INSERT, 16'h00FF, 16'd65535, 16'd65534);
        send_req(siq_pkg::REQ_INSERT, 16'h0000, 16'd65535, 16'd65535);
        send_req(siq_pkg::REQ_INSERT, 16'hFFFF, 16'd0, 16'd1);
        send_req(siq_pkg::REQ_INSERT, 16'h0001, 16'd1, 16'd2);
        send_req(siq_pkg::REQ_INSERT, 16'h0002, 16'd2, 16'd4);
        send_req(siq_pkg::REQ_INSERT, 16'h0003, 16'd0, 16'd65535);
        repeat (11) begin
            match = 16'($urandom_range(65535, 1));
            win   = 16'($urandom_range(match, 0));
            send_req(siq_pkg::REQ_INSERT, 16'($urandom_range(65535, 0)), win, match);
        end
        send_req(siq_pkg::REQ_INSERT, 16'h8000, 16'd0, 16'd0);
        send_req(siq_pkg::REQ_DUMP, 16'h0000, 16'h0000, 16'h0000);
        send_req(siq_pkg::REQ_POP, 16'h0000, 16'h0000, 16'h0000);
        wait_drained();

        // random part
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case ($urandom_range(2, 0))
                0: ins_pct = 20;
                1: ins_pct = 50;
                default: ins_pct = 80;
            endcase
            if (ph == RANDOM_PHASES / 2) wait_drained();
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                tag   = 16'($urandom_range(65535, 0));
                win   = 16'($urandom_range(65535, 0));
                match = 16'($urandom_range(65535, 0));
                roll  = $urandom_range(99, 0);
                if (roll < 3) begin
                    req = REQ_IGNORED;
                end else begin
                    sent++;
                    if (roll < 3 + ins_pct) begin
                        req     = siq_pkg::REQ_INSERT;
                        variant = $urandom_range(9, 0);
                        case (variant)
                            0: match = 16'd0;
                            1: begin
                                match = 16'($urandom_range(65534, 0));
                                win   = 16'($urandom_range(65535, match + 1));
                            end
                            2, 3, 4: begin
                                match = 16'($urandom_range(8, 1));
                                win   = 16'($urandom_range(match, 0));
                            end
                            5: begin
                                match = 16'($urandom_range(65535, 1));
                                win   = match;
                            end
                            default: begin
                                match = 16'($urandom_range(65535, 1));
                                win   = 16'($urandom_range(match, 0));
                            end
                        endcase
                    end else if ($urandom_range(9, 0) < 7) begin
                        req = siq_pkg::REQ_POP;
                    end else begin
                        req = siq_pkg::REQ_DUMP;
                    end
                end
                send_req(req, tag, win, match);
                pace();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
